// File: rtl/core/bds4_pkg.sv
package bds4_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int SUM_W    = 10;
    localparam int IMG_W_W  = 12;
    localparam int IMG_H_W  = 13;
    localparam int SIZE_W   = 13;
    localparam int ROW_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    // row phase within a band of four rows
    localparam logic [1:0] PH_ROW0 = 2'd0;
    localparam logic [1:0] PH_ROW1 = 2'd1;
    localparam logic [1:0] PH_ROW2 = 2'd2;
    localparam logic [1:0] PH_ROW3 = 2'd3;

    typedef struct packed {
        logic             frame_end;
        logic             row_end;
        logic [PIX_W-1:0] rgb;
    } out_item_t;

    // rounded-up average per 8-bit channel
    function automatic logic [PIX_W-1:0] avg_px(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        logic [CH_W:0]    s;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            s = {1'b0, a[k*CH_W +: CH_W]} + {1'b0, b[k*CH_W +: CH_W]} + 9'd1;
            r[k*CH_W +: CH_W] = s[CH_W:1];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/box_downscale_4x_rgb.sv
// 4x4 box downscaler, RGB, raster order in.
// Throughput: 1 input item/cycle while the output queue has room; row 3 of a band gives
// 1 result per 4 items (1 in 16 overall). A result goes through the line store read, then
// vertical/horizontal reduce into a 2-entry output queue, from which it is offered.
// Reset (rst_n low, async): row/column counters, horizontal sums and queue cleared, sizes
// back to 640 x 480; line stores are not cleared and are only read after being written.
module box_downscale_4x_rgb #(
    parameter int MAX_WIDTH = bds4_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: in_red[7:0], in_green[15:8], in_blue[23:16]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bds4_pkg::PIX_W-1:0]        s_tdata,
    // m_tdata: out_red[7:0], out_green[15:8], out_blue[23:16]; tlast: row_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bds4_pkg::PIX_W-1:0]        m_tdata,
    output logic                              m_tlast,
    // m_tuser: frame_end[0]
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bds4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bds4_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = bds4_pkg::SIZE_W;
    localparam int PW = bds4_pkg::PIX_W;
    localparam int HW = bds4_pkg::SUM_W;
    localparam int CHW = bds4_pkg::CH_W;

    logic [bds4_pkg::IMG_W_W-1:0] image_width_reg;
    logic [bds4_pkg::IMG_H_W-1:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bds4_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= bds4_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bds4_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[bds4_pkg::IMG_W_W-1:0];
                bds4_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [SW-1:0] eff_w;
    logic [SW-1:0] eff_h;

    always_comb
    begin
        eff_w = {1'b0, image_width_reg[bds4_pkg::IMG_W_W-1:2], 2'b00};
        if (eff_w < SW'(4))
            eff_w = SW'(4);
        if (eff_w > SW'(MAX_WIDTH))
            eff_w = SW'(MAX_WIDTH);
        eff_h = {image_height_reg[bds4_pkg::IMG_H_W-1:2], 2'b00};
        if (eff_h < SW'(4))
            eff_h = SW'(4);
        if (eff_h > SW'(bds4_pkg::MAX_HEIGHT))
            eff_h = SW'(bds4_pkg::MAX_HEIGHT);
    end

    // stage 0: position counters, line store reads
    logic [CW-1:0]                 col_reg;
    logic [bds4_pkg::ROW_W-1:0]    row_reg;
    logic                          s_accept;
    logic                          last_col;
    logic                          last_row;
    logic                          emit;

    assign s_accept = s_tvalid && s_tready;
    assign last_col = (SW'(col_reg) + SW'(1)) >= eff_w;
    assign last_row = (SW'(row_reg) + SW'(1)) >= eff_h;
    assign emit     = (row_reg[1:0] == bds4_pkg::PH_ROW3) && (col_reg[1:0] == 2'b11);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    logic [1:0]           s1_phase_reg;
    logic [1:0]           s1_col_lo_reg;
    logic [CW-1:0]        s1_idx_reg;
    logic [PW-1:0]        s1_px_reg;
    logic                 s1_last_col_reg;
    logic                 s1_last_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s_accept;
            s1_emit_reg  <= s_accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_phase_reg    <= row_reg[1:0];
            s1_col_lo_reg   <= col_reg[1:0];
            s1_idx_reg      <= col_reg;
            s1_px_reg       <= s_tdata;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // line stores; stage 1 writes back at the previous column, stage 0 reads the next,
    // so the same entry is never read and written in one cycle
    logic [PW-1:0] pair_mem  [MAX_WIDTH];
    logic [PW-1:0] third_mem [MAX_WIDTH];
    logic [PW-1:0] pair_rd_reg;
    logic [PW-1:0] third_rd_reg;
    logic          pair_we;
    logic          third_we;
    logic [PW-1:0] pair_wdata;

    assign pair_we  = s1_valid_reg && ((s1_phase_reg == bds4_pkg::PH_ROW0) ||
                                       (s1_phase_reg == bds4_pkg::PH_ROW1));
    assign third_we = s1_valid_reg && (s1_phase_reg == bds4_pkg::PH_ROW2);
    assign pair_wdata = (s1_phase_reg == bds4_pkg::PH_ROW0) ? s1_px_reg
                                                            : bds4_pkg::avg_px(pair_rd_reg, s1_px_reg);

    always_ff @(posedge clk)
    begin
        if (pair_we)
            pair_mem[s1_idx_reg] <= pair_wdata;
        if (s_accept)
            pair_rd_reg <= pair_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (third_we)
            third_mem[s1_idx_reg] <= s1_px_reg;
        if (s_accept)
            third_rd_reg <= third_mem[col_reg];
    end

    // stage 1: vertical reduce and horizontal sums
    logic [3*HW-1:0]         hsum_reg;
    logic [3*HW-1:0]         hsum_next;
    logic [PW-1:0]           vert;
    bds4_pkg::out_item_t     push_item;
    logic                    hsum_we;

    assign hsum_we = s1_valid_reg && (s1_phase_reg == bds4_pkg::PH_ROW3);

    always_comb
    begin
        vert = bds4_pkg::avg_px(pair_rd_reg, bds4_pkg::avg_px(third_rd_reg, s1_px_reg));
        for (int k = 0; k < 3; k++)
        begin
            hsum_next[k*HW +: HW] = ((s1_col_lo_reg != 2'b00) ? hsum_reg[k*HW +: HW] : HW'(0))
                                    + HW'(vert[k*CHW +: CHW]);
            push_item.rgb[k*CHW +: CHW] = hsum_next[k*HW+2 +: CHW];
        end
        push_item.row_end   = s1_last_col_reg;
        push_item.frame_end = s1_last_col_reg && s1_last_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hsum_reg <= '0;
        else if (hsum_we)
            hsum_reg <= hsum_next;
    end

    // 2-entry output queue; an emitting item in stage 1 holds a slot
    bds4_pkg::out_item_t fifo_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                push;
    logic                pop;

    assign push = s1_emit_reg;
    assign pop  = m_tvalid && m_tready;

    assign s_tready = (count_reg + 2'(s1_emit_reg)) < 2'd2;
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = fifo_reg[rd_ptr_reg].rgb;
    assign m_tlast  = fifo_reg[rd_ptr_reg].row_end;
    assign m_tuser  = fifo_reg[rd_ptr_reg].frame_end;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/core/bds4_checker.sv
module bds4_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [bds4_pkg::PIX_W-1:0]        s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bds4_pkg::PIX_W-1:0]        m_tdata,
    input logic                              m_tlast,
    input logic [0:0]                        m_tuser,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [bds4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [bds4_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output item changed while stalled");

    // frame end is always also a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame_end without row_end");

    // nothing offered out of reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    // a result into an empty queue follows an accepted input item through stage 1 and the queue
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output item without a preceding input item");

endmodule

bind box_downscale_4x_rgb bds4_checker u_bds4_checker (.*);

// File: tb/sv/downscale_checker.sv
`timescale 1ns / 1ps

module downscale_checker
    import bds4_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [PIX_W-1:0]      m_tdata,
    input  logic                  m_tlast,
    input  logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    outstanding,
    output int                    mismatches
);

    logic [PIX_W-1:0]   pair_line  [MAX_WIDTH];
    logic [PIX_W-1:0]   third_line [MAX_WIDTH];
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [3*SUM_W-1:0] hsum;
    out_item_t          scaled_due [$];
    out_item_t          due;

    function automatic logic [PIX_W-1:0] mean_up(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        logic [CH_W:0]    s;
        int               k;
        for (k = 0; k < 3; k++)
        begin
            s = {1'b0, a[k*CH_W +: CH_W]} + {1'b0, b[k*CH_W +: CH_W]} + 1'b1;
            r[k*CH_W +: CH_W] = s[CH_W:1];
        end
        return r;
    endfunction

    function automatic int unsigned span(input int unsigned v, input int unsigned hi);
        int unsigned e;
        e = v & ~32'd3;
        if (e < 4)
            e = 4;
        if (e > hi)
            e = hi;
        return e;
    endfunction

    task automatic shrink_pixel(input logic [PIX_W-1:0] px);
        int unsigned        w;
        int unsigned        h;
        logic               last_col;
        logic               last_row;
        logic [PIX_W-1:0]   v;
        logic [3*SUM_W-1:0] s;
        logic [SUM_W-1:0]   prev;
        out_item_t          o;
        int                 k;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        case (row_pos[1:0])
            PH_ROW0: pair_line[col_pos] = px;
            PH_ROW1: pair_line[col_pos] = mean_up(pair_line[col_pos], px);
            PH_ROW2: third_line[col_pos] = px;
            PH_ROW3:
            begin
                v = mean_up(pair_line[col_pos], mean_up(third_line[col_pos], px));
                for (k = 0; k < 3; k++)
                begin
                    prev = (col_pos[1:0] != 2'd0) ? hsum[k*SUM_W +: SUM_W] : '0;
                    s[k*SUM_W +: SUM_W] = prev + SUM_W'(v[k*CH_W +: CH_W]);
                end
                hsum = s;
                if (col_pos[1:0] == 2'd3)
                begin
                    for (k = 0; k < 3; k++)
                        o.rgb[k*CH_W +: CH_W] = s[k*SUM_W + 2 +: CH_W];
                    o.row_end   = last_col;
                    o.frame_end = last_col & last_row;
                    scaled_due.push_back(o);
                end
            end
        endcase
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : (row_pos + 1) % MAX_HEIGHT;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   = RST_IMAGE_WIDTH;
            height_reg  = RST_IMAGE_HEIGHT;
            col_pos     = 0;
            row_pos     = 0;
            hsum        = '0;
            scaled_due.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (scaled_due.size() == 0)
                begin
                    $error("output item with no downscaled pixel due");
                    mismatches++;
                end
                else
                begin
                    due = scaled_due.pop_front();
                    check_field("out_red", due.rgb[7:0], m_tdata[7:0]);
                    check_field("out_green", due.rgb[15:8], m_tdata[15:8]);
                    check_field("out_blue", due.rgb[23:16], m_tdata[23:16]);
                    check_field("row_end", due.row_end, m_tlast);
                    check_field("frame_end", due.frame_end, m_tuser[0]);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_H_W-1:0];
                endcase
            end
            if (s_tvalid && s_tready)
                shrink_pixel(s_tdata);
            outstanding = scaled_due.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bds4_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 500;

    typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_MIXED} fill_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic gap_on   = 1'b1;
    logic stall_on = 1'b1;
    int   outstanding;
    int   mismatches;
    int   cycle_count = 0;

    logic [PIX_W-1:0] opening_px [16] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
        24'hFF0000, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF,
        24'h555555, 24'hAAAAAA, 24'h010101, 24'h808080,
        24'h7F7F7F, 24'hFEFEFE, 24'h0F0F0F, 24'hF0F0F0
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    box_downscale_4x_rgb u_top (.*);

    downscale_checker u_check (.*);

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
        int unsigned e;
        e = v & ~32'd3;
        if (e < 4)
            e = 4;
        if (e > hi)
            e = hi;
        return e;
    endfunction

    function automatic logic [PIX_W-1:0] pick_px(input fill_t fill);
        logic [PIX_W-1:0] p;
        int               k;
        p = PIX_W'($urandom);
        case (fill)
            FILL_MAX:  p = '1;
            FILL_ZERO: p = '0;
            FILL_MIXED:
            begin
                for (k = 0; k < 3; k++)
                begin
                    case ($urandom_range(0, 2))
                        0: p[k*CH_W +: CH_W] = '0;
                        1: p[k*CH_W +: CH_W] = '1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_px(input logic [PIX_W-1:0] px);
        if (gap_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_run(input int n, input fill_t fill);
        int i;
        for (i = 0; i < n; i++)
            send_px(pick_px(fill));
    endtask

    task automatic write_sizes(input logic [CFG_DATA_W-1:0] w,
                               input logic [CFG_DATA_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every due pixel, then let the pipeline drain
    task automatic settle;
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int                    random_sent;
        int                    items;
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;
        fill_t                 fill;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // row 0 runs at the reset width of 640; width 16 then closes it at column 16
        foreach (opening_px[i])
            send_px(opening_px[i]);
        settle;
        write_sizes(13'd16, 13'd4);
        send_run(49, FILL_RANDOM);
        settle;

        // height drops under row 4: that row closes the frame
        write_sizes(13'd4, 13'd8);
        send_run(16, FILL_RANDOM);
        settle;
        write_sizes(13'd0, 13'd3);
        send_run(4, FILL_RANDOM);
        send_run(16, FILL_MAX);
        send_run(16, FILL_ZERO);
        settle;

        // width cut to 4 at column 6 of row 7: that group gives no output
        write_sizes(13'd16, 13'd8);
        send_run(118, FILL_MIXED);
        settle;
        write_sizes(13'd4, 13'd8);
        send_run(33, FILL_RANDOM);
        settle;

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= RANDOM_ITEMS * 3 / 4)
            begin
                gap_on   <= 1'b0;
                stall_on <= 1'b0;
            end
            case ($urandom_range(0, 3))
                0, 1: wv = CFG_DATA_W'(16 * $urandom_range(1, 2));
                2: wv = CFG_DATA_W'($urandom_range(0, 40));
                default: wv = CFG_DATA_W'(4 * $urandom_range(1, 10));
            endcase
            hv = CFG_DATA_W'($urandom_range(0, 13));
            case ($urandom_range(0, 7))
                5: fill = FILL_MAX;
                6: fill = FILL_ZERO;
                7: fill = FILL_MIXED;
                default: fill = FILL_RANDOM;
            endcase
            items = eff_size(wv, DEF_MAX_WIDTH) * eff_size(hv, MAX_HEIGHT);
            write_sizes(wv, hv);
            send_run(items, fill);
            settle;
            random_sent += items;
        end

        @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
